@@ rtl/core/pqwc_pkg.sv @@
// pqwc_pkg: shared constants for the pair qinv window cut.
// No dependencies.
`timescale 1ns / 1ps

package pqwc_pkg;

  // register indexes on the cfg port
  localparam logic [1:0] CFG_TRACK_MASS  = 2'd0;
  localparam logic [1:0] CFG_WINDOW_LOW  = 2'd1;
  localparam logic [1:0] CFG_WINDOW_HIGH = 2'd2;

  // pair kinds
  localparam logic [1:0] KIND_ORDINARY   = 2'd0;
  localparam logic [1:0] KIND_HEMISPHERE = 2'd1;
  localparam logic [1:0] KIND_ROTATED    = 2'd2;

  localparam int MASS_W   = 14;
  localparam int MSQ_W    = 2 * MASS_W;
  localparam int QINV_W   = 20;
  localparam int CFG_W    = 20;
  localparam int ENERGY_FRAC = 16;

  localparam logic [QINV_W-1:0] Q_MAX         = 20'hFFFFF;
  localparam logic [MASS_W-1:0] MASS_RESET    = 14'd140;
  localparam logic [QINV_W-1:0] WLOW_RESET    = 20'd0;
  localparam logic [QINV_W-1:0] WHIGH_RESET   = 20'hFFFFF;

endpackage

@@ rtl/core/pqwc_isqrt.sv @@
// pqwc_isqrt: pipelined integer square root, one root bit per stage.
// Standalone; N register stages, advance on en.
`timescale 1ns / 1ps

module pqwc_isqrt #(
  parameter int N = 36
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [2*N-1:0] in_rad,
  output logic           out_valid,
  output logic [N-1:0]   out_root
);

  localparam int RW = N + 3;

  logic [2*N-1:0] rad_r  [N];
  logic [RW-1:0]  rem_r  [N];
  logic [N-1:0]   root_r [N];
  logic           v_r    [N];

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      logic [2*N-1:0] rad_p;
      logic [RW-1:0]  rem_p;
      logic [N-1:0]   root_p;
      logic           v_p;
      logic [RW-1:0]  rem_sh;
      logic [RW-1:0]  trial;
      logic           ge;
      logic [RW-1:0]  rem_nxt;
      logic [N-1:0]   root_nxt;

      if (k == 0) begin : g_first
        assign rad_p  = in_rad;
        assign rem_p  = '0;
        assign root_p = '0;
        assign v_p    = in_valid;
      end else begin : g_next
        assign rad_p  = rad_r[k-1];
        assign rem_p  = rem_r[k-1];
        assign root_p = root_r[k-1];
        assign v_p    = v_r[k-1];
      end

      // bring down the next two radicand bits, try (root*4 + 1)
      assign rem_sh   = {rem_p[RW-3:0], rad_p[2*N-1 -: 2]};
      assign trial    = RW'({root_p, 2'b01});
      assign ge       = (rem_sh >= trial);
      assign rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      assign root_nxt = {root_p[N-2:0], ge};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en) begin
          v_r[k] <= v_p;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rad_r[k]  <= rad_p << 2;
          rem_r[k]  <= rem_nxt;
          root_r[k] <= root_nxt;
        end
      end
    end
  endgenerate

  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1];

endmodule

@@ rtl/core/pair_qinv_window_cut.sv @@
// pair_qinv_window_cut: qinv of a track pair plus inclusive window test.
// Uses pqwc_pkg and two kinds of pqwc_isqrt instances (energies, q).
`timescale 1ns / 1ps

//  channel | dir | handshake            | words
//  --------+-----+----------------------+-------------------------------------
//  in_     | in  | in_valid / in_ready  | two momenta (x,y,z), pair kind
//  out_    | out | out_valid / out_ready| qinv value, in-window flag
//  cfg_    | in  | cfg_we               | track mass, window low, window high
//
//  One word per cycle sustained while the output queue has room. A word
//  runs through stages 1 to 3, the energy roots, stages 4 to 7 and the q
//  root; the bit-per-stage square roots (energy, then q) have EW stages each.
//  rst_n is synchronous; it clears valid bits, the output queue and the config
//  registers, and in_ready stays low while it is asserted. A stall freezes the
//  whole pipe; a two-word output queue lets a new word enter while a finished
//  one waits on out_ready.

module pair_qinv_window_cut #(
  parameter int MOMENTUM_BITS = 19
) (
  input  logic                             clk,
  input  logic                             rst_n,

  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [MOMENTUM_BITS-1:0]  in_first_px,
  input  logic signed [MOMENTUM_BITS-1:0]  in_first_py,
  input  logic signed [MOMENTUM_BITS-1:0]  in_first_pz,
  input  logic signed [MOMENTUM_BITS-1:0]  in_second_px,
  input  logic signed [MOMENTUM_BITS-1:0]  in_second_py,
  input  logic signed [MOMENTUM_BITS-1:0]  in_second_pz,
  input  logic [1:0]                       in_pair_kind,

  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pqwc_pkg::QINV_W-1:0]      out_qinv_value,
  output logic                             out_in_window,

  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [pqwc_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int M    = MOMENTUM_BITS;
  localparam int EF   = pqwc_pkg::ENERGY_FRAC;
  localparam int QW   = pqwc_pkg::QINV_W;
  // |p|^2 + m^2 width
  localparam int SW   = (2*M + 2 > pqwc_pkg::MSQ_W + 1) ? 2*M + 2 : pqwc_pkg::MSQ_W + 1;
  localparam int DPW  = 2*M + 2;               // |dp|^2
  localparam int EW   = (SW + 1) / 2 + EF;     // energy, EF fraction bits
  localparam int RADW = 2 * EW;                // radicands, dE^2, diff
  localparam int L    = (EW + 1) / 2;          // split of dE for squaring
  localparam int H    = EW - L;
  localparam int QF   = EW - EF;
  localparam int CW   = (QF > QW) ? QF : QW;

  // ---------------- configuration ----------------
  logic [pqwc_pkg::MASS_W-1:0] mass_r;
  logic [QW-1:0]               wlow_r;
  logic [QW-1:0]               whigh_r;
  logic [pqwc_pkg::MSQ_W-1:0]  msq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r  <= pqwc_pkg::MASS_RESET;
      wlow_r  <= pqwc_pkg::WLOW_RESET;
      whigh_r <= pqwc_pkg::WHIGH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pqwc_pkg::CFG_TRACK_MASS:  mass_r  <= cfg_wdata[pqwc_pkg::MASS_W-1:0];
        pqwc_pkg::CFG_WINDOW_LOW:  wlow_r  <= cfg_wdata[QW-1:0];
        pqwc_pkg::CFG_WINDOW_HIGH: whigh_r <= cfg_wdata[QW-1:0];
        default: ;
      endcase
    end
  end

  // mass squared, kept ready; config only changes while idle is a rule for the user, not enforced by the block
  always_ff @(posedge clk) begin
    msq_r <= pqwc_pkg::MSQ_W'(mass_r) * pqwc_pkg::MSQ_W'(mass_r);
  end

  // ---------------- global advance ----------------
  logic [1:0] cnt_r;
  logic       en;

  assign en       = (cnt_r != 2'd2);
  // no word is taken while reset is held
  assign in_ready = en && rst_n;

  // ---------------- stage 1: magnitudes and pair difference ----------------
  logic signed [M:0] ax, ay, az, bx, by, bz;
  logic signed [M:0] dx, dy, dz;
  logic [M-1:0]      ma_nxt [3];
  logic [M-1:0]      mb_nxt [3];
  logic [M:0]        md_nxt [3];

  assign ax = {in_first_px[M-1],  in_first_px};
  assign ay = {in_first_py[M-1],  in_first_py};
  assign az = {in_first_pz[M-1],  in_first_pz};
  assign bx = {in_second_px[M-1], in_second_px};
  assign by = {in_second_py[M-1], in_second_py};
  assign bz = {in_second_pz[M-1], in_second_pz};

  always_comb begin
    case (in_pair_kind)
      pqwc_pkg::KIND_HEMISPHERE: begin
        dx = ax + bx;
        dy = ay + by;
        dz = az + bz;
      end
      pqwc_pkg::KIND_ROTATED: begin
        dx = ax + bx;
        dy = ay + by;
        dz = az - bz;
      end
      default: begin
        // ordinary, and the unused fourth code
        dx = ax - bx;
        dy = ay - by;
        dz = az - bz;
      end
    endcase
  end

  // negation of the most negative value wraps to the right unsigned magnitude
  assign ma_nxt[0] = in_first_px[M-1]  ? $unsigned(-in_first_px)  : $unsigned(in_first_px);
  assign ma_nxt[1] = in_first_py[M-1]  ? $unsigned(-in_first_py)  : $unsigned(in_first_py);
  assign ma_nxt[2] = in_first_pz[M-1]  ? $unsigned(-in_first_pz)  : $unsigned(in_first_pz);
  assign mb_nxt[0] = in_second_px[M-1] ? $unsigned(-in_second_px) : $unsigned(in_second_px);
  assign mb_nxt[1] = in_second_py[M-1] ? $unsigned(-in_second_py) : $unsigned(in_second_py);
  assign mb_nxt[2] = in_second_pz[M-1] ? $unsigned(-in_second_pz) : $unsigned(in_second_pz);
  assign md_nxt[0] = dx[M] ? $unsigned(-dx) : $unsigned(dx);
  assign md_nxt[1] = dy[M] ? $unsigned(-dy) : $unsigned(dy);
  assign md_nxt[2] = dz[M] ? $unsigned(-dz) : $unsigned(dz);

  logic [M-1:0] ma_r [3];
  logic [M-1:0] mb_r [3];
  logic [M:0]   md_r [3];
  logic         v1_r;

  // ---------------- stage 2: squares ----------------
  logic [2*M-1:0] pa_r [3];
  logic [2*M-1:0] pb_r [3];
  logic [DPW-1:0] pd_r [3];
  logic           v2_r;

  // ---------------- stage 3: sums ----------------
  logic [SW-1:0]  s1_r, s2_r;
  logic [DPW-1:0] dp2_r;
  logic           v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ma_r[i] <= ma_nxt[i];
        mb_r[i] <= mb_nxt[i];
        md_r[i] <= md_nxt[i];
        pa_r[i] <= (2*M)'(ma_r[i]) * (2*M)'(ma_r[i]);
        pb_r[i] <= (2*M)'(mb_r[i]) * (2*M)'(mb_r[i]);
        pd_r[i] <= DPW'(md_r[i]) * DPW'(md_r[i]);
      end
      s1_r  <= SW'(pa_r[0]) + SW'(pa_r[1]) + SW'(pa_r[2]) + SW'(msq_r);
      s2_r  <= SW'(pb_r[0]) + SW'(pb_r[1]) + SW'(pb_r[2]) + SW'(msq_r);
      dp2_r <= pd_r[0] + pd_r[1] + pd_r[2];
    end
  end

  // ---------------- energies: E = isqrt((|p|^2 + m^2) << 2*EF) ----------------
  logic [RADW-1:0] rad1, rad2;
  logic            ve1, ve2;
  logic [EW-1:0]   e1, e2;

  assign rad1 = RADW'(s1_r) << (2*EF);
  assign rad2 = RADW'(s2_r) << (2*EF);

  pqwc_isqrt #(.N(EW)) u_energy1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_rad    (rad1),
    .out_valid (ve1),
    .out_root  (e1)
  );

  pqwc_isqrt #(.N(EW)) u_energy2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_rad    (rad2),
    .out_valid (ve2),
    .out_root  (e2)
  );

  // |dp|^2 rides alongside the energy roots
  logic [DPW-1:0] dp2_d [EW];

  always_ff @(posedge clk) begin
    if (en) begin
      dp2_d[0] <= dp2_r;
      for (int i = 1; i < EW; i++) begin
        dp2_d[i] <= dp2_d[i-1];
      end
    end
  end

  // ---------------- stage 4..7: |dE^2 - |dp|^2| ----------------
  logic [EW-1:0]   de_r;
  logic [DPW-1:0]  dp2_4_r, dp2_5_r;
  logic [2*H-1:0]  hh_r;
  logic [EW-1:0]   hl_r;
  logic [2*L-1:0]  ll_r;
  logic [RADW-1:0] de2_r, dps_r, diff_r;
  logic            v4_r, v5_r, v6_r, v7_r;
  logic [H-1:0]    de_hi;
  logic [L-1:0]    de_lo;

  assign de_hi = de_r[EW-1:L];
  assign de_lo = de_r[L-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v4_r <= ve1 & ve2;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      de_r    <= (e1 >= e2) ? (e1 - e2) : (e2 - e1);
      dp2_4_r <= dp2_d[EW-1];
      // dE squared as three partial products
      hh_r    <= (2*H)'(de_hi) * (2*H)'(de_hi);
      hl_r    <= EW'(de_hi) * EW'(de_lo);
      ll_r    <= (2*L)'(de_lo) * (2*L)'(de_lo);
      dp2_5_r <= dp2_4_r;
      de2_r   <= (RADW'(hh_r) << (2*L)) + (RADW'(hl_r) << (L+1)) + RADW'(ll_r);
      dps_r   <= RADW'(dp2_5_r) << (2*EF);
      diff_r  <= (de2_r >= dps_r) ? (de2_r - dps_r) : (dps_r - de2_r);
    end
  end

  // ---------------- q = isqrt(diff) >> EF ----------------
  logic          vq;
  logic [EW-1:0] qroot;

  pqwc_isqrt #(.N(EW)) u_qinv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v7_r),
    .in_rad    (diff_r),
    .out_valid (vq),
    .out_root  (qroot)
  );

  logic [CW-1:0] qwide;
  logic [QW-1:0] qsat;
  logic          inwin;

  assign qwide = CW'(qroot[EW-1:EF]);
  assign qsat  = (qwide > CW'(pqwc_pkg::Q_MAX)) ? pqwc_pkg::Q_MAX : qwide[QW-1:0];
  assign inwin = (qsat >= wlow_r) && (qsat <= whigh_r);

  // ---------------- two-word output queue ----------------
  logic [QW-1:0] q0_r, q1_r;
  logic          w0_r, w1_r;
  logic          push, pop;

  assign push = en && vq;
  assign pop  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push && (pop || cnt_r == 2'd0)) begin
      // head is free this cycle (empty, or single word leaving)
      q0_r <= qsat;
      w0_r <= inwin;
    end else if (pop) begin
      q0_r <= q1_r;
      w0_r <= w1_r;
    end
    if (push && !pop && cnt_r == 2'd1) begin
      q1_r <= qsat;
      w1_r <= inwin;
    end
  end

  assign out_valid      = (cnt_r != 2'd0);
  assign out_qinv_value = q0_r;
  assign out_in_window  = w0_r;

endmodule
